// File: sv/sit_pkg.sv
// Shared types and constants for the sorted insert table.
`default_nettype none

package sit_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int IDX_W        = 4;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // memory read address source; the scan pointer follows every read
    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_TOP  = 3'd1,
        RD_IDX  = 3'd2,
        RD_DOWN = 3'd3,
        RD_UP   = 3'd4
    } rd_src_t;

    // memory write address and data source
    typedef enum logic [2:0] {
        WR_NONE       = 3'd0,
        WR_KEY_ZERO   = 3'd1,
        WR_KEY_ABOVE  = 3'd2,
        WR_SHIFT_UP   = 3'd3,
        WR_SHIFT_DOWN = 3'd4
    } wr_src_t;

    typedef enum logic [2:0] {
        RES_HOLD  = 3'd0,
        RES_DONE  = 3'd1,
        RES_FULL  = 3'd2,
        RES_RANGE = 3'd3,
        RES_TAKE  = 3'd4
    } res_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_LAST,
        S_LOOK,
        S_REM_TAKE,
        S_REM_SCAN,
        S_FIN
    } state_t;

    typedef struct packed {
        logic    load;
        rd_src_t rd_src;
        wr_src_t wr_src;
        logic    fill_inc;
        logic    fill_dec;
        res_op_t res_op;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  is_full;
        logic  idx_bad;
        logic  fill_zero;
        logic  key_lt;
        logic  cur_zero;
        logic  more;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/sorted_insert_table.sv
// Sorted insert table top level: ascending key table with insert, lookup and remove.
// Throughput: one item at a time; the scans over the key memory (one read and one
//   write port), one entry a cycle, set the rate.
// Reset (rst_n, async low) empties the table and clears the handshake state;
//   stored keys are not cleared, only keys below the fill count are ever read.
`default_nettype none

module sorted_insert_table #(
    parameter int CAPACITY = sit_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input item channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sit_pkg::MODE_W-1:0]    mode,
    input  wire logic [sit_pkg::KEY_W-1:0]     key,
    input  wire logic [sit_pkg::IDX_W-1:0]     index,
    // result item channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [sit_pkg::KEY_W-1:0]     data,
    output logic      [sit_pkg::STATUS_W-1:0]  status,
    output logic      [sit_pkg::COUNT_W-1:0]   count
);
    import sit_pkg::*;

    // Commands flow from the controller into the datapath, status back.
    // Insert scans down from the top entry, moving each larger-or-equal key
    // up one slot, and drops the new key in above the first smaller one.
    // Remove reads the taken key, then moves each later key down one slot.
    // The result sits in an output register, so the next item can be taken
    // while the previous result waits.
    cmd_t cmd;
    sts_t sts;

    sit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sit_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .mode   (mode),
        .key    (key),
        .index  (index),
        .data   (data),
        .status (status),
        .count  (count)
    );

endmodule

`default_nettype wire

// File: sv/sit_dp.sv
// Datapath: key memory, fill count, scan pointer and result registers.
`default_nettype none

module sit_dp #(
    parameter int CAPACITY = sit_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sit_pkg::cmd_t                 cmd,
    output sit_pkg::sts_t                      sts,
    input  wire logic [sit_pkg::MODE_W-1:0]    mode,
    input  wire logic [sit_pkg::KEY_W-1:0]     key,
    input  wire logic [sit_pkg::IDX_W-1:0]     index,
    output logic      [sit_pkg::KEY_W-1:0]     data,
    output logic      [sit_pkg::STATUS_W-1:0]  status,
    output logic      [sit_pkg::COUNT_W-1:0]   count
);
    import sit_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > IDX_W) ? FW : IDX_W;

    logic [KEY_W-1:0] mem [CAPACITY];

    mode_t            mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [KEY_W-1:0] rd_data_reg;
    status_t          res_status_reg, res_status_next;
    logic [KEY_W-1:0] res_data_reg, res_data_next;
    logic [KEY_W-1:0] data_reg;
    status_t          status_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [FW-1:0]    fill_m1;
    logic [AW-1:0]    idx_addr;
    logic [AW-1:0]    cur_up;
    logic [AW-1:0]    cur_down;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic             wr_en;

    assign fill_m1  = fill_reg - FW'(1);
    assign idx_addr = AW'(idx_reg);
    assign cur_up   = cur_reg + AW'(1);
    assign cur_down = cur_reg - AW'(1);

    // status to the controller
    assign sts.mode      = mode_reg;
    assign sts.is_full   = (fill_reg == FW'(CAPACITY));
    assign sts.idx_bad   = (CW'(idx_reg) >= CW'(fill_reg));
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.key_lt    = (rd_data_reg < key_reg);
    assign sts.cur_zero  = (cur_reg == '0);
    assign sts.more      = ((FW'(cur_reg) + FW'(1)) < fill_reg);

    always_comb
    begin
        rd_en    = 1'b1;
        rd_addr  = cur_reg;
        cur_next = cur_reg;
        unique case (cmd.rd_src)
            RD_TOP:  rd_addr = fill_m1[AW-1:0];
            RD_IDX:  rd_addr = idx_addr;
            RD_DOWN: rd_addr = cur_down;
            RD_UP:   rd_addr = cur_up;
            default: rd_en   = 1'b0;
        endcase
        if (rd_en)
        begin
            cur_next = rd_addr;
        end
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = cur_up;
        wr_data = rd_data_reg;
        unique case (cmd.wr_src)
            WR_KEY_ZERO:
            begin
                wr_addr = '0;
                wr_data = key_reg;
            end
            WR_KEY_ABOVE:  wr_data = key_reg;
            WR_SHIFT_UP:   wr_addr = cur_up;
            WR_SHIFT_DOWN: wr_addr = cur_down;
            default:       wr_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_inc)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_m1;
        end
    end

    always_comb
    begin
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        unique case (cmd.res_op)
            RES_DONE:
            begin
                res_status_next = ST_DONE;
                res_data_next   = '0;
            end
            RES_FULL:
            begin
                res_status_next = ST_FULL;
                res_data_next   = '0;
            end
            RES_RANGE:
            begin
                res_status_next = ST_RANGE;
                res_data_next   = '0;
            end
            RES_TAKE:
            begin
                res_status_next = ST_DONE;
                res_data_next   = rd_data_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(mode);
            key_reg  <= key;
            idx_reg  <= index;
        end
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        if (cmd.out_load)
        begin
            data_reg   <= res_data_reg;
            status_reg <= res_status_reg;
            count_reg  <= COUNT_W'(fill_reg);
        end
    end

    assign data   = data_reg;
    assign status = status_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

// File: sv/sit_ctrl.sv
// Controller: operation sequencing and handshake state machine.
`default_nettype none

module sit_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire sit_pkg::sts_t sts,
    output sit_pkg::cmd_t      cmd
);
    import sit_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            S_DECODE:
                unique case (sts.mode)
                    MODE_INSERT:
                        if (sts.is_full || sts.fill_zero)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_INS_SCAN;
                        end
                    MODE_LOOKUP:
                        state_next = sts.idx_bad ? S_FIN : S_LOOK;
                    MODE_REMOVE:
                        state_next = sts.idx_bad ? S_FIN : S_REM_TAKE;
                    default:
                        state_next = S_FIN;
                endcase
            S_INS_SCAN:
                if (sts.key_lt)
                begin
                    state_next = S_FIN;
                end
                else if (sts.cur_zero)
                begin
                    state_next = S_INS_LAST;
                end
            S_INS_LAST:
                state_next = S_FIN;
            S_LOOK:
                state_next = S_FIN;
            S_REM_TAKE:
                state_next = sts.more ? S_REM_SCAN : S_FIN;
            S_REM_SCAN:
                if (!sts.more)
                begin
                    state_next = S_FIN;
                end
            S_FIN:
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_DECODE:
            begin
                cmd.res_op = RES_DONE;
                unique case (sts.mode)
                    MODE_INSERT:
                        if (sts.is_full)
                        begin
                            cmd.res_op = RES_FULL;
                        end
                        else if (sts.fill_zero)
                        begin
                            cmd.wr_src   = WR_KEY_ZERO;
                            cmd.fill_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_src = RD_TOP;
                        end
                    MODE_LOOKUP, MODE_REMOVE:
                        if (sts.idx_bad)
                        begin
                            cmd.res_op = RES_RANGE;
                        end
                        else
                        begin
                            cmd.rd_src = RD_IDX;
                        end
                    default: ;
                endcase
            end
            S_INS_SCAN:
                if (sts.key_lt)
                begin
                    cmd.wr_src   = WR_KEY_ABOVE;
                    cmd.fill_inc = 1'b1;
                end
                else
                begin
                    cmd.wr_src = WR_SHIFT_UP;
                    if (!sts.cur_zero)
                    begin
                        cmd.rd_src = RD_DOWN;
                    end
                end
            S_INS_LAST:
            begin
                cmd.wr_src   = WR_KEY_ZERO;
                cmd.fill_inc = 1'b1;
            end
            S_LOOK:
                cmd.res_op = RES_TAKE;
            S_REM_TAKE:
            begin
                cmd.res_op = RES_TAKE;
                if (sts.more)
                begin
                    cmd.rd_src = RD_UP;
                end
                else
                begin
                    cmd.fill_dec = 1'b1;
                end
            end
            S_REM_SCAN:
            begin
                cmd.wr_src = WR_SHIFT_DOWN;
                if (sts.more)
                begin
                    cmd.rd_src = RD_UP;
                end
                else
                begin
                    cmd.fill_dec = 1'b1;
                end
            end
            S_FIN:
                cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == S_FIN && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
